// ===== design/sbab_pkg.sv =====
// Shared types, constants and codes of the stretch blit alpha blend engine.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package sbab_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = DIM_W + FRAC_W;
    localparam int ACC_W       = 41;
    localparam int PROD_W      = DIM_W + STEP_W;
    localparam int CLIP_CALC_W = DIM_W + 3;
    localparam int TEXEL_W     = 32;
    localparam int PIXEL_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int DIV_STEPS   = STEP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_COLOR   = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_STARTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CLIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BLENDED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic               clipped;
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [DIM_W-1:0]   span_w;
        logic [DIM_W-1:0]   span_h;
        logic [DIM_W-1:0]   skip_u;
        logic [DIM_W-1:0]   skip_v;
        logic [DIM_W-1:0]   full_w;
        logic [DIM_W-1:0]   full_h;
        logic [DIM_W-1:0]   src_w;
        logic [DIM_W-1:0]   src_h;
        logic [TEXEL_W-1:0] texel;
        logic [PIXEL_W-1:0] dst_pixel;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PIXEL_W-1:0]  blended_pixel;
        logic [COORD_W-1:0]  write_x;
        logic [COORD_W-1:0]  write_y;
        logic [COORD_W-1:0]  next_dst_x;
        logic [COORD_W-1:0]  next_dst_y;
        logic [COORD_W-1:0]  next_src_u;
        logic [COORD_W-1:0]  next_src_v;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/sbab_ifs.sv =====
// Channel interfaces of the blit engine: request, response and register write.
// Depends on sbab_pkg for field widths.
`default_nettype none

interface sbab_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [sbab_pkg::DIM_W-1:0] dst_x;
    logic signed [sbab_pkg::DIM_W-1:0] dst_y;
    logic [sbab_pkg::DIM_W-1:0]        dst_w;
    logic [sbab_pkg::DIM_W-1:0]        dst_h;
    logic [sbab_pkg::DIM_W-1:0]        src_w;
    logic [sbab_pkg::DIM_W-1:0]        src_h;
    logic [sbab_pkg::TEXEL_W-1:0]      texel;
    logic [sbab_pkg::PIXEL_W-1:0]      dst_pixel;

    modport source (output valid, req_type, dst_x, dst_y, dst_w, dst_h, src_w, src_h,
                    texel, dst_pixel, input ready);
    modport sink (input valid, req_type, dst_x, dst_y, dst_w, dst_h, src_w, src_h,
                  texel, dst_pixel, output ready);
endinterface

interface sbab_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sbab_pkg::STATUS_W-1:0] status;
    logic [sbab_pkg::PIXEL_W-1:0]  blended_pixel;
    logic [sbab_pkg::COORD_W-1:0]  write_x;
    logic [sbab_pkg::COORD_W-1:0]  write_y;
    logic [sbab_pkg::COORD_W-1:0]  next_dst_x;
    logic [sbab_pkg::COORD_W-1:0]  next_dst_y;
    logic [sbab_pkg::COORD_W-1:0]  next_src_u;
    logic [sbab_pkg::COORD_W-1:0]  next_src_v;
    logic                          last;

    modport source (output valid, status, blended_pixel, write_x, write_y, next_dst_x,
                    next_dst_y, next_src_u, next_src_v, last, input ready);
    modport sink (input valid, status, blended_pixel, write_x, write_y, next_dst_x,
                  next_dst_y, next_src_u, next_src_v, last, output ready);
endinterface

interface sbab_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sbab_pkg::CFG_IDX_W-1:0]  index;
    logic [sbab_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/sbab_front.sv =====
// Front end: register bank, request intake, rectangle clipping and texel modulation.
// Depends on sbab_pkg and the channel interfaces; feeds sbab_queue.
`default_nettype none

module sbab_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    sbab_req_if.sink               req,
    sbab_cfg_if.sink               cfg,
    input  wire logic              full,
    output logic                   push,
    output sbab_pkg::entry_t       push_data
);

    logic [sbab_pkg::DIM_W-1:0]      clip_left_reg;
    logic [sbab_pkg::DIM_W-1:0]      clip_top_reg;
    logic [sbab_pkg::DIM_W-1:0]      clip_right_reg;
    logic [sbab_pkg::DIM_W-1:0]      clip_bottom_reg;
    logic [sbab_pkg::CFG_DATA_W-1:0] mod_color_reg;

    logic signed [sbab_pkg::CLIP_CALC_W-1:0] x0, y0, w0, h0;
    logic signed [sbab_pkg::CLIP_CALC_W-1:0] x1, y1, w1, h1, w2, h2;
    logic signed [sbab_pkg::CLIP_CALC_W-1:0] cl, ct, cr, cb;
    logic signed [sbab_pkg::CLIP_CALC_W-1:0] skip_u, skip_v;
    logic [sbab_pkg::TEXEL_W-1:0]            mod_texel;
    logic [2*8-1:0]                          byte_prod;

    function automatic logic [sbab_pkg::DIM_W-1:0] eff_clip(
        input logic [sbab_pkg::DIM_W-1:0] v
    );
        if (v > sbab_pkg::DIM_W'(sbab_pkg::MAX_DIM))
        begin
            return sbab_pkg::DIM_W'(sbab_pkg::MAX_DIM);
        end
        return v;
    endfunction

    assign cfg.ready = 1'b1;
    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= sbab_pkg::DIM_W'(sbab_pkg::MAX_DIM);
            clip_bottom_reg <= sbab_pkg::DIM_W'(sbab_pkg::MAX_DIM);
            mod_color_reg   <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sbab_pkg::REG_CLIP_LEFT:   clip_left_reg   <= cfg.data[sbab_pkg::DIM_W-1:0];
                sbab_pkg::REG_CLIP_TOP:    clip_top_reg    <= cfg.data[sbab_pkg::DIM_W-1:0];
                sbab_pkg::REG_CLIP_RIGHT:  clip_right_reg  <= cfg.data[sbab_pkg::DIM_W-1:0];
                sbab_pkg::REG_CLIP_BOTTOM: clip_bottom_reg <= cfg.data[sbab_pkg::DIM_W-1:0];
                sbab_pkg::REG_MOD_COLOR:   mod_color_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        x0 = {{3{req.dst_x[sbab_pkg::DIM_W-1]}}, req.dst_x};
        y0 = {{3{req.dst_y[sbab_pkg::DIM_W-1]}}, req.dst_y};
        w0 = {3'b000, req.dst_w};
        h0 = {3'b000, req.dst_h};
        cl = {3'b000, eff_clip(clip_left_reg)};
        ct = {3'b000, eff_clip(clip_top_reg)};
        cr = {3'b000, eff_clip(clip_right_reg)};
        cb = {3'b000, eff_clip(clip_bottom_reg)};

        if (x0 < cl)
        begin
            skip_u = cl - x0;
            w1     = w0 - skip_u;
            x1     = cl;
        end
        else
        begin
            skip_u = '0;
            w1     = w0;
            x1     = x0;
        end
        if (y0 < ct)
        begin
            skip_v = ct - y0;
            h1     = h0 - skip_v;
            y1     = ct;
        end
        else
        begin
            skip_v = '0;
            h1     = h0;
            y1     = y0;
        end
        w2 = (x1 + w1 > cr) ? cr - x1 : w1;
        h2 = (y1 + h1 > cb) ? cb - y1 : h1;
    end

    always_comb
    begin
        mod_texel = req.texel;
        byte_prod = '0;
        if (mod_color_reg != '1)
        begin
            for (int i = 0; i < 4; i++)
            begin
                byte_prod = req.texel[8*i +: 8] * mod_color_reg[8*i +: 8];
                mod_texel[8*i +: 8] = byte_prod[15:8];
            end
        end
    end

    always_comb
    begin
        push_data.req_type  = req.req_type;
        push_data.clipped   = (w2 <= 0) || (h2 <= 0);
        push_data.org_x     = x1[sbab_pkg::COORD_W-1:0];
        push_data.org_y     = y1[sbab_pkg::COORD_W-1:0];
        push_data.span_w    = w2[sbab_pkg::DIM_W-1:0];
        push_data.span_h    = h2[sbab_pkg::DIM_W-1:0];
        push_data.skip_u    = skip_u[sbab_pkg::DIM_W-1:0];
        push_data.skip_v    = skip_v[sbab_pkg::DIM_W-1:0];
        push_data.full_w    = req.dst_w;
        push_data.full_h    = req.dst_h;
        push_data.src_w     = req.src_w;
        push_data.src_h     = req.src_h;
        push_data.texel     = mod_texel;
        push_data.dst_pixel = req.dst_pixel;
    end

endmodule

`default_nettype wire

// ===== design/sbab_queue.sv =====
// Short queue of classified requests between the front end and the back end.
// Depends on sbab_pkg for the entry type and depth.
`default_nettype none

module sbab_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sbab_pkg::entry_t push_data,
    output logic                  full,
    output logic                  head_valid,
    output sbab_pkg::entry_t      head,
    input  wire logic             pop
);

    sbab_pkg::entry_t             entries_reg [sbab_pkg::QUEUE_DEPTH];
    logic [sbab_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [sbab_pkg::QCNT_W-1:0]  count_reg;

    function automatic logic [sbab_pkg::QPTR_W-1:0] ptr_inc(
        input logic [sbab_pkg::QPTR_W-1:0] p
    );
        if (p == sbab_pkg::QPTR_W'(sbab_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full       = (count_reg == sbab_pkg::QCNT_W'(sbab_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/sbab_back.sv =====
// Back end: step division, rectangle walk, alpha blend and the response register.
// Depends on sbab_pkg and the response interface; drained from sbab_queue.
`default_nettype none

module sbab_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire sbab_pkg::entry_t head,
    output logic                  pop,
    sbab_rsp_if.source            rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [sbab_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sbab_pkg::DIM_W-1:0]      rem_u_reg, rem_u_next, rem_v_reg, rem_v_next;
    logic [sbab_pkg::STEP_W-1:0]     num_u_reg, num_u_next, num_v_reg, num_v_next;
    logic                            busy_reg, busy_next;
    logic [sbab_pkg::COORD_W-1:0]    origin_col_reg, origin_col_next;
    logic [sbab_pkg::COORD_W-1:0]    origin_row_reg, origin_row_next;
    logic [sbab_pkg::DIM_W-1:0]      span_w_reg, span_w_next, span_h_reg, span_h_next;
    logic [sbab_pkg::DIM_W-1:0]      col_reg, col_next, row_reg, row_next;
    logic [sbab_pkg::STEP_W-1:0]     u_step_reg, u_step_next, v_step_reg, v_step_next;
    logic [sbab_pkg::ACC_W-1:0]      u_start_reg, u_start_next;
    logic [sbab_pkg::ACC_W-1:0]      u_accum_reg, u_accum_next, v_accum_reg, v_accum_next;
    sbab_pkg::rsp_t                  out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            out_free;
    logic [sbab_pkg::PROD_W-1:0]     prod_u, prod_v;
    logic [sbab_pkg::DIM_W:0]        shift_u, shift_v;
    logic                            ge_u, ge_v;
    logic [sbab_pkg::DIM_W-1:0]      col_plus, row_plus, col_wrap, row_wrap;
    logic                            wrap, done;

    function automatic logic [7:0] mix(
        input logic [7:0] d,
        input logic [7:0] s,
        input logic [7:0] a
    );
        logic [15:0] sum;
        sum = d * (8'd255 - a) + s * a;
        return sum[15:8];
    endfunction

    assign out_free = !out_valid_reg || rsp.ready;

    assign shift_u = {rem_u_reg, num_u_reg[sbab_pkg::STEP_W-1]};
    assign shift_v = {rem_v_reg, num_v_reg[sbab_pkg::STEP_W-1]};
    assign ge_u    = shift_u >= {1'b0, head.full_w};
    assign ge_v    = shift_v >= {1'b0, head.full_h};
    assign prod_u  = head.skip_u * num_u_reg;
    assign prod_v  = head.skip_v * num_v_reg;

    assign col_plus = col_reg + 1'b1;
    assign row_plus = row_reg + 1'b1;
    assign wrap     = col_plus >= span_w_reg;
    assign col_wrap = wrap ? '0 : col_plus;
    assign row_wrap = wrap ? row_plus : row_reg;
    assign done     = row_wrap >= span_h_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_u_next      = rem_u_reg;
        rem_v_next      = rem_v_reg;
        num_u_next      = num_u_reg;
        num_v_next      = num_v_reg;
        busy_next       = busy_reg;
        origin_col_next = origin_col_reg;
        origin_row_next = origin_row_reg;
        span_w_next     = span_w_reg;
        span_h_next     = span_h_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        u_step_next     = u_step_reg;
        v_step_next     = v_step_reg;
        u_start_next    = u_start_reg;
        u_accum_next    = u_accum_reg;
        v_accum_next    = v_accum_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        pop             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    priority if (head.req_type == sbab_pkg::REQ_START && !head.clipped)
                    begin
                        rem_u_next = '0;
                        rem_v_next = '0;
                        num_u_next = {head.src_w, {sbab_pkg::FRAC_W{1'b0}}};
                        num_v_next = {head.src_h, {sbab_pkg::FRAC_W{1'b0}}};
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        priority if (head.req_type == sbab_pkg::REQ_START)
                        begin
                            busy_next       = 1'b0;
                            out_next.status = sbab_pkg::STAT_CLIPPED;
                        end
                        else if (!busy_reg)
                        begin
                            out_next.status = sbab_pkg::STAT_IGNORED;
                        end
                        else
                        begin
                            out_next.status        = sbab_pkg::STAT_BLENDED;
                            out_next.blended_pixel = {
                                mix(head.dst_pixel[23:16], head.texel[7:0], head.texel[31:24]),
                                mix(head.dst_pixel[15:8], head.texel[15:8], head.texel[31:24]),
                                mix(head.dst_pixel[7:0], head.texel[23:16], head.texel[31:24])};
                            out_next.write_x = origin_col_reg + col_reg[sbab_pkg::COORD_W-1:0];
                            out_next.write_y = origin_row_reg + row_reg[sbab_pkg::COORD_W-1:0];
                            col_next = col_wrap;
                            row_next = row_wrap;
                            if (wrap)
                            begin
                                u_accum_next = u_start_reg;
                                v_accum_next = v_accum_reg + sbab_pkg::ACC_W'(v_step_reg);
                            end
                            else
                            begin
                                u_accum_next = u_accum_reg + sbab_pkg::ACC_W'(u_step_reg);
                            end
                            if (done)
                            begin
                                busy_next     = 1'b0;
                                out_next.last = 1'b1;
                            end
                            else
                            begin
                                out_next.next_dst_x =
                                    origin_col_reg + col_wrap[sbab_pkg::COORD_W-1:0];
                                out_next.next_dst_y =
                                    origin_row_reg + row_wrap[sbab_pkg::COORD_W-1:0];
                                out_next.next_src_u = u_accum_next[
                                    sbab_pkg::FRAC_W+sbab_pkg::COORD_W-1:sbab_pkg::FRAC_W];
                                out_next.next_src_v = v_accum_next[
                                    sbab_pkg::FRAC_W+sbab_pkg::COORD_W-1:sbab_pkg::FRAC_W];
                            end
                        end
                    end
                    else
                    begin
                    end
                end
            end
            S_DIV:
            begin
                rem_u_next = ge_u ? shift_u[sbab_pkg::DIM_W-1:0] - head.full_w
                                  : shift_u[sbab_pkg::DIM_W-1:0];
                rem_v_next = ge_v ? shift_v[sbab_pkg::DIM_W-1:0] - head.full_h
                                  : shift_v[sbab_pkg::DIM_W-1:0];
                num_u_next = {num_u_reg[sbab_pkg::STEP_W-2:0], ge_u};
                num_v_next = {num_v_reg[sbab_pkg::STEP_W-2:0], ge_v};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == sbab_pkg::DIV_CNT_W'(sbab_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                u_step_next  = num_u_reg;
                v_step_next  = num_v_reg;
                u_start_next = prod_u[sbab_pkg::ACC_W-1:0];
                u_accum_next = prod_u[sbab_pkg::ACC_W-1:0];
                v_accum_next = prod_v[sbab_pkg::ACC_W-1:0];
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    pop             = 1'b1;
                    busy_next       = 1'b1;
                    origin_col_next = head.org_x;
                    origin_row_next = head.org_y;
                    span_w_next     = head.span_w;
                    span_h_next     = head.span_h;
                    col_next        = '0;
                    row_next        = '0;
                    out_valid_next  = 1'b1;
                    out_next        = '0;
                    out_next.status     = sbab_pkg::STAT_STARTED;
                    out_next.next_dst_x = head.org_x;
                    out_next.next_dst_y = head.org_y;
                    out_next.next_src_u = u_accum_reg[
                        sbab_pkg::FRAC_W+sbab_pkg::COORD_W-1:sbab_pkg::FRAC_W];
                    out_next.next_src_v = v_accum_reg[
                        sbab_pkg::FRAC_W+sbab_pkg::COORD_W-1:sbab_pkg::FRAC_W];
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        rem_u_reg      <= rem_u_next;
        rem_v_reg      <= rem_v_next;
        num_u_reg      <= num_u_next;
        num_v_reg      <= num_v_next;
        origin_col_reg <= origin_col_next;
        origin_row_reg <= origin_row_next;
        span_w_reg     <= span_w_next;
        span_h_reg     <= span_h_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        u_step_reg     <= u_step_next;
        v_step_reg     <= v_step_next;
        u_start_reg    <= u_start_next;
        u_accum_reg    <= u_accum_next;
        v_accum_reg    <= v_accum_next;
        out_reg        <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.blended_pixel = out_reg.blended_pixel;
    assign rsp.write_x       = out_reg.write_x;
    assign rsp.write_y       = out_reg.write_y;
    assign rsp.next_dst_x    = out_reg.next_dst_x;
    assign rsp.next_dst_y    = out_reg.next_dst_y;
    assign rsp.next_src_u    = out_reg.next_src_u;
    assign rsp.next_src_v    = out_reg.next_src_v;
    assign rsp.last          = out_reg.last;

endmodule

`default_nettype wire

// ===== design/stretch_blit_alpha_blend.sv =====
// Top level of the alpha blended stretch blit engine: front end, queue, back end.
// Depends on sbab_pkg, the channel interfaces, sbab_front, sbab_queue and sbab_back.
//
// Channel  Direction  Carries
// req      in         start rectangles and pixels with fetched texel and destination
// rsp      out        status, blended pixel, its position and the next fetch point
// cfg      in         clip rectangle and modulate color register writes
//
// Pixels stream through the back end at one per cycle while the response register
// is not stalled. A start beat that is not fully clipped runs the bit-serial
// divider that forms both 13.16 steps, one quotient bit per cycle, then a multiply
// state and a state that issues the response. Reset clears the queue, the busy flag
// and the response valid flag and resets the register bank. A two-entry queue takes
// requests until full while the response register is stalled.
`default_nettype none

module stretch_blit_alpha_blend (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbab_req_if.sink    req,
    sbab_rsp_if.source  rsp,
    sbab_cfg_if.sink    cfg
);

    logic             push;
    sbab_pkg::entry_t push_data;
    logic             full;
    logic             head_valid;
    sbab_pkg::entry_t head;
    logic             pop;

    sbab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    sbab_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sbab_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
